>>> rtl/rpp_pkg.sv
// Shared types, constants and sequencer states for the pure pursuit steering unit.
// No dependencies.
`default_nettype none
package rpp_pkg;

  localparam int MAX_POINTS_DEF = 256;

  // config port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_LOOKAHEAD = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MAX_SPEED = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GOAL_TOL  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_TURN  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CURV_THR  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIN_RATIO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_DECEL     = 3'd6;
  localparam logic [CFG_IW-1:0] REG_REG_EN    = 3'd7;

  localparam logic [14:0] LOOKAHEAD_RST = 15'd2048;
  localparam logic [14:0] MAX_SPEED_RST = 15'd1229;
  localparam logic [14:0] GOAL_TOL_RST  = 15'd410;
  localparam logic [14:0] MAX_TURN_RST  = 15'd2048;
  localparam logic [15:0] CURV_THR_RST  = 16'd2048;
  localparam logic [12:0] MIN_RATIO_RST = 13'd1229;
  localparam logic [14:0] DECEL_RST     = 15'd2048;

  // 0.15 m in Q3.12
  localparam logic [14:0] LA_MIN = 15'd614;
  localparam logic [14:0] SPEED_SAT = 15'h7FFF;

  // shared divider: |y|<<25 is the widest dividend, squared distance the widest divisor
  localparam int DIV_NW = 41;
  localparam int DIV_DW = 32;
  localparam int SQRT_IW = 32;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
    logic               empty_path;
  } in_word_t;

  typedef struct packed {
    logic [14:0]        linear_speed;
    logic signed [15:0] turn_rate;
    logic               stop_cmd;
    logic               overflowed;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GSQ, S_GSUM, S_GSQRT, S_LA, S_LA2,
    S_RD, S_SQ, S_CMP, S_NF,
    S_K, S_KW, S_V, S_C, S_CW, S_P, S_PW, S_PS,
    S_MIN, S_CAP, S_CAPW, S_SAT, S_W, S_WC, S_OUT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/rpp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses rpp_pkg for the status struct.
`default_nettype none
module rpp_div #(
  parameter int NW = rpp_pkg::DIV_NW,
  parameter int DW = rpp_pkg::DIV_DW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output rpp_pkg::unit_stat_t stat,
  output logic [NW-1:0]      quo
);
  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  rem;
  logic [DW-1:0]  dsr;
  logic [NW-1:0]  nsh;
  logic [CNW-1:0] cnt;
  logic [DW:0]    trial;
  logic           ge;

  assign trial = {rem, nsh[NW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNW'(NW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nsh <= num;
      dsr <= den;
      quo <= '0;
    end else if (stat.busy) begin
      rem <= ge ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      nsh <= {nsh[NW-2:0], 1'b0};
      quo <= {quo[NW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> rtl/rpp_sqrt.sv
// Digit-by-digit integer square root (floor), one root bit per cycle.
// Uses rpp_pkg for the status struct.
`default_nettype none
module rpp_sqrt #(
  parameter int IW = rpp_pkg::SQRT_IW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [IW-1:0] radicand,
  output rpp_pkg::unit_stat_t stat,
  output logic [IW/2-1:0]    root
);
  localparam int RW  = IW / 2;
  localparam int CNW = $clog2(RW + 1);

  logic [RW+1:0]  rem;
  logic [IW-1:0]  vsh;
  logic [CNW-1:0] cnt;
  logic [RW+3:0]  rem_n;
  logic [RW+3:0]  trial;
  logic           ge;

  assign rem_n = {rem, vsh[IW-1:IW-2]};
  assign trial = (RW+4)'({root, 2'b01});
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNW'(RW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      vsh  <= radicand;
      root <= '0;
    end else if (stat.busy) begin
      rem  <= ge ? (RW+2)'(rem_n - trial) : rem_n[RW+1:0];
      vsh  <= {vsh[IW-3:0], 2'b00};
      root <= {root[RW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> rtl/regulated_pure_pursuit_steering_unit.sv
// Regulated pure pursuit steering: path points load at one word per cycle while the
// sequencer is idle. Intermediate point: accepted, no result. Empty-path word: the sequencer
// goes straight to its output state and loads the output register once the receiver does not
// stall. Goal word: the result follows the search over N stored points (read, square and
// compare states per point), up to four 41-bit divides and two 16-bit roots. Input stalls until the result
// is in the output register. Sync active-high reset clears point count, overflow flag,
// control, and loads config defaults; memory is not cleared.
`default_nettype none
module regulated_pure_pursuit_steering_unit #(
  parameter int MAX_POINTS = rpp_pkg::MAX_POINTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire rpp_pkg::in_word_t          in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rpp_pkg::out_word_t              out_word,
  input  wire logic                       cfg_we,
  input  wire logic [rpp_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [rpp_pkg::CFG_DW-1:0] cfg_data
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = rpp_pkg::DIV_NW;
  localparam int DW = rpp_pkg::DIV_DW;

  // ---------------- configuration registers ----------------
  logic [14:0] lookahead, max_speed, goal_tol, max_turn, decel;
  logic [15:0] curv_thr;
  logic [12:0] min_ratio;
  logic        reg_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= rpp_pkg::LOOKAHEAD_RST;
      max_speed <= rpp_pkg::MAX_SPEED_RST;
      goal_tol  <= rpp_pkg::GOAL_TOL_RST;
      max_turn  <= rpp_pkg::MAX_TURN_RST;
      curv_thr  <= rpp_pkg::CURV_THR_RST;
      min_ratio <= rpp_pkg::MIN_RATIO_RST;
      decel     <= rpp_pkg::DECEL_RST;
      reg_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rpp_pkg::REG_LOOKAHEAD: lookahead <= cfg_data[14:0];
        rpp_pkg::REG_MAX_SPEED: max_speed <= cfg_data[14:0];
        rpp_pkg::REG_GOAL_TOL:  goal_tol  <= cfg_data[14:0];
        rpp_pkg::REG_MAX_TURN:  max_turn  <= cfg_data[14:0];
        rpp_pkg::REG_CURV_THR:  curv_thr  <= cfg_data;
        rpp_pkg::REG_MIN_RATIO: min_ratio <= cfg_data[12:0];
        rpp_pkg::REG_DECEL:     decel     <= cfg_data[14:0];
        rpp_pkg::REG_REG_EN:    reg_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  rpp_pkg::state_t state, state_next;

  logic          acc;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic          out_free;

  // point memory: x in low half, y in high half
  logic [31:0]   mem [MAX_POINTS];
  logic [31:0]   rd_data;
  logic          rd_en;
  logic [CW-1:0] idx;

  // datapath
  logic signed [15:0] gx, gy, ly;
  logic [30:0]        sa, sb;
  logic [31:0]        gd2, d2, sum2;
  logic [15:0]        dg;
  logic [14:0]        la, la_c;
  logic [29:0]        la2;
  logic [25:0]        kmag;
  logic               ksign;
  logic [16:0]        v;
  logic [15:0]        vmin;
  logic [28:0]        wprod;
  logic [14:0]        wmag;
  logic [15:0]        aly;
  logic [14:0]        res_speed;
  logic [15:0]        res_turn;
  logic               res_stop;

  // shared arithmetic units
  logic          div_start, sqrt_start;
  logic [NW-1:0] div_num, quo;
  logic [DW-1:0] div_den;
  logic [rpp_pkg::SQRT_IW-1:0] sqrt_in;
  logic [15:0]   root;
  rpp_pkg::unit_stat_t div_stat, sqrt_stat;

  rpp_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .stat(div_stat), .quo(quo)
  );

  rpp_sqrt #(.IW(rpp_pkg::SQRT_IW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sqrt_in),
    .stat(sqrt_stat), .root(root)
  );

  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign sum2     = 32'(sa) + 32'(sb);
  assign aly      = ly[15] ? 16'(-ly) : 16'(ly);
  // lookahead = min(cfg, goal distance), at least 0.15 m
  assign la_c     = (16'(lookahead) < dg) ? lookahead : dg[14:0];
  assign vmin     = 16'((28'(max_speed) * 28'(min_ratio)) >> 12);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      rpp_pkg::S_IDLE: begin
        if (acc) begin
          if (in_word.empty_path)      state_next = rpp_pkg::S_OUT;
          else if (in_word.last_point) state_next = rpp_pkg::S_GSQ;
        end
      end
      rpp_pkg::S_GSQ:   state_next = rpp_pkg::S_GSUM;
      rpp_pkg::S_GSUM:  state_next = rpp_pkg::S_GSQRT;
      rpp_pkg::S_GSQRT: if (sqrt_stat.done) state_next = rpp_pkg::S_LA;
      rpp_pkg::S_LA:    state_next = rpp_pkg::S_LA2;
      rpp_pkg::S_LA2:   state_next = rpp_pkg::S_RD;
      rpp_pkg::S_RD:    state_next = (idx == cnt) ? rpp_pkg::S_NF : rpp_pkg::S_SQ;
      rpp_pkg::S_SQ:    state_next = rpp_pkg::S_CMP;
      rpp_pkg::S_CMP:   state_next = (sum2 >= 32'(la2)) ? rpp_pkg::S_K : rpp_pkg::S_RD;
      rpp_pkg::S_NF:    state_next = (dg < 16'(goal_tol)) ? rpp_pkg::S_OUT : rpp_pkg::S_K;
      rpp_pkg::S_K:     state_next = (d2 == '0) ? rpp_pkg::S_V : rpp_pkg::S_KW;
      rpp_pkg::S_KW:    if (div_stat.done) state_next = rpp_pkg::S_V;
      rpp_pkg::S_V:     state_next = rpp_pkg::S_C;
      rpp_pkg::S_C: begin
        if (!reg_en)                        state_next = rpp_pkg::S_SAT;
        else if (26'(curv_thr) < kmag)      state_next = rpp_pkg::S_CW;
        else                                state_next = rpp_pkg::S_P;
      end
      rpp_pkg::S_CW:    if (div_stat.done) state_next = rpp_pkg::S_P;
      rpp_pkg::S_P:     state_next = (dg < 16'(decel)) ? rpp_pkg::S_PW : rpp_pkg::S_MIN;
      rpp_pkg::S_PW:    if (div_stat.done) state_next = rpp_pkg::S_PS;
      rpp_pkg::S_PS:    if (sqrt_stat.done) state_next = rpp_pkg::S_MIN;
      rpp_pkg::S_MIN:   state_next = rpp_pkg::S_CAP;
      rpp_pkg::S_CAP: begin
        if (17'(dg) < {1'b0, goal_tol, 1'b0}) state_next = rpp_pkg::S_CAPW;
        else                                  state_next = rpp_pkg::S_SAT;
      end
      rpp_pkg::S_CAPW:  if (div_stat.done) state_next = rpp_pkg::S_SAT;
      rpp_pkg::S_SAT:   state_next = rpp_pkg::S_W;
      rpp_pkg::S_W:     state_next = rpp_pkg::S_WC;
      rpp_pkg::S_WC:    state_next = rpp_pkg::S_OUT;
      rpp_pkg::S_OUT:   if (out_free) state_next = rpp_pkg::S_IDLE;
      default:          state_next = rpp_pkg::S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_stall   = (state != rpp_pkg::S_IDLE);
    rd_en      = (state == rpp_pkg::S_RD) && (idx != cnt);
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    sqrt_in    = sum2;
    unique case (state)
      rpp_pkg::S_GSUM: sqrt_start = 1'b1;
      rpp_pkg::S_K: begin
        // curvature magnitude |y| * 2^25 / d^2
        div_start = (d2 != '0);
        div_num   = {aly, 25'b0};
        div_den   = d2;
      end
      rpp_pkg::S_C: begin
        div_start = reg_en && (26'(curv_thr) < kmag);
        div_num   = NW'(31'(v[14:0]) * 31'(curv_thr));
        div_den   = DW'(kmag);
      end
      rpp_pkg::S_P: begin
        div_start = (dg < 16'(decel));
        div_num   = NW'({dg[14:0], 24'b0});
        div_den   = DW'(decel);
      end
      rpp_pkg::S_PW: begin
        // proximity factor = sqrt(dg * 2^24 / decel)
        sqrt_start = div_stat.done;
        sqrt_in    = rpp_pkg::SQRT_IW'(quo[23:0]);
      end
      rpp_pkg::S_CAP: begin
        div_start = (17'(dg) < {1'b0, goal_tol, 1'b0});
        div_num   = NW'(31'(max_speed) * 31'(dg));
        div_den   = DW'({goal_tol, 1'b0});
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpp_pkg::S_IDLE;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (acc && !in_word.empty_path) begin
        if (cnt < CW'(MAX_POINTS)) cnt <= cnt + 1'b1;
        else                       ovf <= 1'b1;
      end
      if (state == rpp_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
        cnt       <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  // ---------------- point memory ----------------
  always_ff @(posedge clk) begin
    if (acc && !in_word.empty_path && cnt < CW'(MAX_POINTS))
      mem[cnt[AW-1:0]] <= {in_word.point_y, in_word.point_x};
    if (rd_en)
      rd_data <= mem[idx[AW-1:0]];
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      rpp_pkg::S_IDLE: begin
        gx       <= in_word.point_x;
        gy       <= in_word.point_y;
        res_stop <= 1'b1;
        res_speed <= '0;
        res_turn  <= '0;
      end
      rpp_pkg::S_GSQ: begin
        sa <= 31'(32'(gx * gx));
        sb <= 31'(32'(gy * gy));
      end
      rpp_pkg::S_GSUM:  gd2 <= sum2;
      rpp_pkg::S_GSQRT: if (sqrt_stat.done) dg <= root;
      rpp_pkg::S_LA:    la <= (la_c < rpp_pkg::LA_MIN) ? rpp_pkg::LA_MIN : la_c;
      rpp_pkg::S_LA2: begin
        la2 <= 30'(la) * 30'(la);
        idx <= '0;
      end
      rpp_pkg::S_SQ: begin
        sa <= 31'(32'($signed(rd_data[15:0]) * $signed(rd_data[15:0])));
        sb <= 31'(32'($signed(rd_data[31:16]) * $signed(rd_data[31:16])));
        ly <= $signed(rd_data[31:16]);
      end
      rpp_pkg::S_CMP: begin
        d2  <= sum2;
        idx <= idx + 1'b1;
      end
      rpp_pkg::S_NF: begin
        // no point beyond lookahead: steer at the goal
        d2 <= gd2;
        ly <= gy;
      end
      rpp_pkg::S_K: begin
        kmag  <= '0;
        ksign <= ly[15];
      end
      rpp_pkg::S_KW:  if (div_stat.done) kmag <= quo[25:0];
      rpp_pkg::S_V:   v <= 17'(max_speed);
      rpp_pkg::S_CW:  if (div_stat.done) v <= quo[16:0];
      rpp_pkg::S_PS:  if (sqrt_stat.done) v <= 17'((33'(v) * 33'(root)) >> 12);
      rpp_pkg::S_MIN: if (v < 17'(vmin)) v <= 17'(vmin);
      rpp_pkg::S_CAPW: if (div_stat.done && NW'(v) > quo) v <= quo[16:0];
      rpp_pkg::S_SAT: if (v > 17'(rpp_pkg::SPEED_SAT)) v <= 17'(rpp_pkg::SPEED_SAT);
      rpp_pkg::S_W:   wprod <= 29'((41'(v[14:0]) * 41'(kmag)) >> 12);
      rpp_pkg::S_WC: begin
        res_stop  <= 1'b0;
        res_speed <= v[14:0];
        res_turn  <= ksign ? 16'(-{1'b0, wmag}) : {1'b0, wmag};
      end
      default: ;
    endcase
  end

  // clamp turn magnitude
  assign wmag = (wprod > 29'(max_turn)) ? max_turn : wprod[14:0];

  // output register, loaded when the sequencer finishes
  always_ff @(posedge clk) begin
    if (state == rpp_pkg::S_OUT && out_free) begin
      out_word.linear_speed <= res_stop ? 15'd0 : res_speed;
      out_word.turn_rate    <= res_stop ? 16'sd0 : $signed(res_turn);
      out_word.stop_cmd     <= res_stop;
      out_word.overflowed   <= ovf;
    end
  end

  // ---------------- assertions ----------------
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> cnt == CW'(MAX_POINTS))
    else $error("overflow flag set with free memory");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_POINTS))
    else $error("point count beyond depth");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.stop_cmd |->
      out_word.linear_speed == 15'd0 && out_word.turn_rate == 16'sd0)
    else $error("stop word with nonzero velocity");

  a_turn_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.turn_rate <= $signed({1'b0, max_turn})) &&
                  (out_word.turn_rate >= -$signed({1'b0, max_turn})))
    else $error("turn rate outside clamp");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy && !sqrt_stat.busy)
    else $error("arith unit restarted while busy");

endmodule
`default_nettype wire

>>> tb/regulated_pure_pursuit_steering_unit_tb.sv
// Self-checking testbench for the regulated pure pursuit steering unit.
// Depends on rpp_pkg and the unit; drives path words, checks steering words.
`default_nettype none
module regulated_pure_pursuit_steering_unit_tb;

  localparam int DEPTH = rpp_pkg::MAX_POINTS_DEF;
  // goal word wait: the search over every stored point plus the divide and root chain
  localparam int GOAL_LAT = 3 * DEPTH + 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  rpp_pkg::in_word_t in_word;
  logic out_valid;
  logic out_stall;
  rpp_pkg::out_word_t out_word;
  logic cfg_we;
  logic [rpp_pkg::CFG_IW-1:0] cfg_index;
  logic [rpp_pkg::CFG_DW-1:0] cfg_data;

  regulated_pure_pursuit_steering_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor copy of the configuration registers.
  logic [14:0] p_lookahead, p_max_speed, p_goal_tol, p_max_turn, p_decel;
  logic [15:0] p_curv_thr;
  logic [12:0] p_min_ratio;
  logic        p_reg_en;

  // Predictor copy of the path memory.
  logic signed [15:0] path_x [DEPTH];
  logic signed [15:0] path_y [DEPTH];
  int unsigned path_len;
  logic        path_ovf;

  rpp_pkg::out_word_t steer_q[$];
  int unsigned n_fail;
  int unsigned n_mismatch;
  bit          hold_off;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dist_sq(longint x, longint y);
    return longint'(x * x + y * y);
  endfunction

  task automatic apply_reg(logic [rpp_pkg::CFG_IW-1:0] idx, logic [rpp_pkg::CFG_DW-1:0] val);
    case (idx)
      rpp_pkg::REG_LOOKAHEAD: p_lookahead = val[14:0];
      rpp_pkg::REG_MAX_SPEED: p_max_speed = val[14:0];
      rpp_pkg::REG_GOAL_TOL:  p_goal_tol  = val[14:0];
      rpp_pkg::REG_MAX_TURN:  p_max_turn  = val[14:0];
      rpp_pkg::REG_CURV_THR:  p_curv_thr  = val;
      rpp_pkg::REG_MIN_RATIO: p_min_ratio = val[12:0];
      rpp_pkg::REG_DECEL:     p_decel     = val[14:0];
      rpp_pkg::REG_REG_EN:    p_reg_en    = val[0];
      default: ;
    endcase
  endtask

  // Steering prediction for one accepted word; returns 1 when a result is due.
  function automatic bit predict_steer(rpp_pkg::in_word_t w, output rpp_pkg::out_word_t r);
    longint unsigned gd2, dg, la, la2, d2, v, ak, vmin, f, cap;
    longint k, m, wr, lyv;
    bit hit;
    r = '0;
    if (w.empty_path) begin
      r.stop_cmd = 1'b1;
      r.overflowed = path_ovf;
      path_len = 0;
      path_ovf = 1'b0;
      return 1'b1;
    end
    if (path_len < DEPTH) begin
      path_x[path_len] = w.point_x;
      path_y[path_len] = w.point_y;
      path_len++;
    end else begin
      path_ovf = 1'b1;
    end
    if (!w.last_point) return 1'b0;

    gd2 = dist_sq(w.point_x, w.point_y);
    dg = int_sqrt(gd2);
    la = (p_lookahead < dg) ? p_lookahead : dg;
    if (la < rpp_pkg::LA_MIN) la = rpp_pkg::LA_MIN;
    la2 = la * la;
    hit = 1'b0;
    lyv = w.point_y;
    d2 = 0;
    for (int i = 0; i < path_len; i++) begin
      if (!hit && dist_sq(path_x[i], path_y[i]) >= la2) begin
        hit = 1'b1;
        lyv = path_y[i];
        d2 = dist_sq(path_x[i], path_y[i]);
      end
    end
    r.overflowed = path_ovf;
    path_len = 0;
    path_ovf = 1'b0;
    if (!hit) begin
      d2 = gd2;
      if (dg < p_goal_tol) begin
        r.stop_cmd = 1'b1;
        return 1'b1;
      end
    end

    k = 0;
    if (d2 != 0) begin
      m = longint'(((lyv < 0 ? -lyv : lyv) << 25) / d2);
      k = (lyv < 0) ? -m : m;
    end
    ak = (k < 0) ? -k : k;
    v = p_max_speed;
    if (p_reg_en) begin
      if (ak > p_curv_thr) v = v * p_curv_thr / ak;
      if (dg < p_decel) begin
        f = int_sqrt((dg << 24) / p_decel);
        v = (v * f) >> 12;
      end
      vmin = (longint'(p_max_speed) * p_min_ratio) >> 12;
      if (v < vmin) v = vmin;
      if (dg < 2 * longint'(p_goal_tol)) begin
        cap = (longint'(p_max_speed) * dg) / (2 * longint'(p_goal_tol));
        if (v > cap) v = cap;
      end
    end
    if (v > 32767) v = 32767;
    m = longint'((v * ak) >> 12);
    wr = (k < 0) ? -m : m;
    if (wr > longint'(p_max_turn)) wr = p_max_turn;
    if (wr < -longint'(p_max_turn)) wr = -longint'(p_max_turn);
    r.linear_speed = v[14:0];
    r.turn_rate = wr[15:0];
    return 1'b1;
  endfunction

  // Drive one path word and wait for its acceptance; queue the prediction.
  task automatic send_word(rpp_pkg::in_word_t w);
    rpp_pkg::out_word_t r;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (predict_steer(w, r)) steer_q = {steer_q, r};
  endtask

  task automatic gap(int unsigned n);
    if (n == 0) return;
    in_valid <= 1'b0;
    in_word <= rpp_pkg::in_word_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Sender burst pacing: after a burst of random length, sometimes a random gap.
  int unsigned burst_left;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 12));
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    // a trailing point word yields nothing; let any goal in flight finish
    repeat (GOAL_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [rpp_pkg::CFG_IW-1:0] idx, logic [rpp_pkg::CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  function automatic rpp_pkg::in_word_t mk(logic [15:0] x, logic [15:0] y, bit last, bit emp);
    rpp_pkg::in_word_t w;
    w.point_x = x;
    w.point_y = y;
    w.last_point = last;
    w.empty_path = emp;
    return w;
  endfunction

  // Random point: mostly near the robot so the lookahead search matters.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
      default: return 16'($signed($urandom_range(0, 24000)) - 12000);
    endcase
  endfunction

  task automatic send_path(int unsigned npts);
    for (int i = 0; i < npts; i++) begin
      pace();
      send_word(mk(rand_coord(), rand_coord(), i == npts - 1, 1'b0));
    end
  endtask

  task automatic random_config();
    write_reg(rpp_pkg::REG_LOOKAHEAD, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                           : $urandom_range(500, 12000)));
    write_reg(rpp_pkg::REG_MAX_SPEED, 16'($urandom_range(0, 32767)));
    write_reg(rpp_pkg::REG_GOAL_TOL, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                          : $urandom_range(0, 2000)));
    write_reg(rpp_pkg::REG_MAX_TURN, 16'($urandom_range(0, 32767)));
    write_reg(rpp_pkg::REG_CURV_THR, 16'($urandom));
    write_reg(rpp_pkg::REG_MIN_RATIO, 16'($urandom_range(0, 8191)));
    write_reg(rpp_pkg::REG_DECEL, 16'($urandom_range(0, 32767)));
    write_reg(rpp_pkg::REG_REG_EN, 16'($urandom_range(0, 3) != 0));
  endtask

  // Directed rows; a row with a typed result is also checked against it.
  typedef struct {
    rpp_pkg::in_word_t  w;
    bit                 typed;
    rpp_pkg::out_word_t exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(rpp_pkg::in_word_t w, bit typed = 0, rpp_pkg::out_word_t exp = '0);
    dir_row_t r;
    r.w = w;
    r.typed = typed;
    r.exp = exp;
    dir_rows = {dir_rows, r};
  endtask

  // Receiver: own stall pattern, plus one long hold-off to back up the input.
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: out_stall <= 1'b1;
          2: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (steer_q.size() == 0) begin
        n_fail++;
        if (n_mismatch++ < 10) $display("unexpected steering word %p", out_word);
      end else begin
        rpp_pkg::out_word_t e;
        e = steer_q.pop_front();
        if (out_word.linear_speed !== e.linear_speed || out_word.turn_rate !== e.turn_rate ||
            out_word.stop_cmd !== e.stop_cmd || out_word.overflowed !== e.overflowed) begin
          n_fail++;
          if (n_mismatch++ < 10)
            $display("steering mismatch: exp speed %0d turn %0d stop %0b ovf %0b, got %0d %0d %0b %0b",
                     e.linear_speed, e.turn_rate, e.stop_cmd, e.overflowed,
                     out_word.linear_speed, out_word.turn_rate,
                     out_word.stop_cmd, out_word.overflowed);
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("regulated_pure_pursuit_steering_unit_tb NOT OK");
    $finish;
  end

  int unsigned n_items;
  int unsigned prev_q;
  rpp_pkg::out_word_t exp_w;

  initial begin
    n_fail = 0;
    n_mismatch = 0;
    hold_off = 0;
    burst_left = 0;
    path_len = 0;
    path_ovf = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    p_lookahead = rpp_pkg::LOOKAHEAD_RST;
    p_max_speed = rpp_pkg::MAX_SPEED_RST;
    p_goal_tol = rpp_pkg::GOAL_TOL_RST;
    p_max_turn = rpp_pkg::MAX_TURN_RST;
    p_curv_thr = rpp_pkg::CURV_THR_RST;
    p_min_ratio = rpp_pkg::MIN_RATIO_RST;
    p_decel = rpp_pkg::DECEL_RST;
    p_reg_en = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under reset defaults.
    exp_w = '0;
    exp_w.stop_cmd = 1'b1;
    add_row(mk(16'h0, 16'h0, 0, 1), 1, exp_w);             // empty path right after reset
    add_row(mk(16'h0100, 16'h0, 1, 1), 1, exp_w);          // both marks: empty wins
    add_row(mk(16'd100, 16'd50, 1, 0), 1, exp_w);          // goal within tolerance
    add_row(mk(16'h0, 16'h0, 1, 0), 1, exp_w);             // goal at origin
    add_row(mk(16'd4096, 16'd0, 1, 0));                    // straight ahead
    add_row(mk(16'h7FFF, 16'h7FFF, 0, 0));                 // far corner
    add_row(mk(16'h8000, 16'h8000, 0, 0));
    add_row(mk(16'd1000, 16'd3000, 1, 0));
    add_row(mk(16'd300, 16'd200, 0, 0));                   // inside lookahead
    add_row(mk(16'd3000, 16'hF000, 0, 0));                 // lookahead hit, turning right
    add_row(mk(16'd8000, 16'd100, 1, 0));
    add_row(mk(16'h8000, 16'h7FFF, 1, 0));
    add_row(mk(16'd5000, 16'd5000, 1, 0));
    add_row(mk(16'h0, 16'h8000, 1, 0));
    add_row(mk(16'd200, 16'hFF00, 0, 0));
    add_row(mk(16'd0, 16'd0, 0, 1), 1, exp_w);              // empty path drops points
    foreach (dir_rows[i]) begin
      prev_q = steer_q.size();
      send_word(dir_rows[i].w);
      if (dir_rows[i].typed && steer_q.size() > prev_q &&
          steer_q[$] !== dir_rows[i].exp) begin
        n_fail++;
        if (n_mismatch++ < 10)
          $display("directed row %0d: exp %p, predicted %p", i, dir_rows[i].exp, steer_q[$]);
      end
    end
    wait_drained();

    // Extreme settings: zero tolerance with goal at origin, enable off, ratio above one.
    write_reg(rpp_pkg::REG_GOAL_TOL, 16'd0);
    write_reg(rpp_pkg::REG_MIN_RATIO, 16'd8191);
    write_reg(rpp_pkg::REG_MAX_SPEED, 16'h7FFF);
    write_reg(rpp_pkg::REG_CURV_THR, 16'hFFFF);
    write_reg(rpp_pkg::REG_MAX_TURN, 16'h7FFF);
    write_reg(rpp_pkg::REG_LOOKAHEAD, 16'h7FFF);
    write_reg(rpp_pkg::REG_DECEL, 16'h7FFF);
    write_reg(rpp_pkg::REG_REG_EN, 16'd1);
    send_word(mk(16'h0, 16'h0, 1, 0));
    send_word(mk(16'd614, 16'd0, 0, 0));
    send_word(mk(16'd10, 16'd600, 1, 0));
    wait_drained();
    write_reg(rpp_pkg::REG_REG_EN, 16'd0);
    send_word(mk(16'd2000, 16'd2000, 1, 0));
    wait_drained();
    write_reg(rpp_pkg::REG_MAX_SPEED, 16'd0);
    write_reg(rpp_pkg::REG_LOOKAHEAD, 16'd0);
    write_reg(rpp_pkg::REG_DECEL, 16'd0);
    write_reg(rpp_pkg::REG_CURV_THR, 16'd0);
    write_reg(rpp_pkg::REG_MAX_TURN, 16'd0);
    write_reg(rpp_pkg::REG_MIN_RATIO, 16'd0);
    write_reg(rpp_pkg::REG_REG_EN, 16'd1);
    send_word(mk(16'd700, 16'd900, 1, 0));
    wait_drained();

    // Overflow path: more points than memory, goal beyond depth.
    random_config();
    for (int i = 0; i < DEPTH + 5; i++) begin
      pace();
      send_word(mk(rand_coord(), rand_coord(), i == DEPTH + 4, 1'b0));
    end
    // overflowed empty path
    for (int i = 0; i < DEPTH + 2; i++) send_word(mk(rand_coord(), rand_coord(), 0, 0));
    send_word(mk(16'h0, 16'h0, 0, 1));

    // Long hold-off on the receiver while goals keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_path($urandom_range(1, 4));
    join
    wait_drained();

    // Random phases with changing settings.
    n_items = 0;
    while (n_items < 1250) begin
      random_config();
      repeat ($urandom_range(5, 20)) begin
        int unsigned n;
        case ($urandom_range(0, 9))
          0: n = 1;
          1: n = $urandom_range(20, 60);
          default: n = $urandom_range(2, 10);
        endcase
        if ($urandom_range(0, 15) == 0) begin
          send_word(mk(rand_coord(), rand_coord(), $urandom_range(0, 1), 1'b1));
          n_items++;
        end else begin
          send_path(n);
          n_items += n;
        end
      end
      // occasionally leave a dangling path before reconfiguring
      if ($urandom_range(0, 3) == 0) send_word(mk(rand_coord(), rand_coord(), 0, 0));
      wait_drained();
    end

    if (n_fail == 0 && steer_q.size() == 0) begin
      $display("regulated_pure_pursuit_steering_unit_tb OK");
    end else begin
      $display("regulated_pure_pursuit_steering_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
